// ----- hw/rtl/deq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_pkg: shared types and constants of the double-ended queue
// Store depth, derived widths, command and status codes, index helpers.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = IDX_W + 1;
  localparam int VAL_W = 32;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_READ_ALL   = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Index of the entry at a given distance from the front, wrapped once
  function automatic idx_t wrap_add(input idx_t base, input cnt_t offset);
    logic [SUM_W-1:0] sum;
    begin
      sum = SUM_W'(base) + SUM_W'(offset);
      if (sum >= SUM_W'(DEPTH)) begin
        sum = sum - SUM_W'(DEPTH);
      end
      wrap_add = sum[IDX_W-1:0];
    end
  endfunction

  // Index one step towards the front, wrapped
  function automatic idx_t wrap_dec(input idx_t base);
    begin
      if (base == '0) begin
        wrap_dec = IDX_W'(DEPTH - 1);
      end else begin
        wrap_dec = base - IDX_W'(1);
      end
    end
  endfunction

  // Index one step towards the back, wrapped
  function automatic idx_t wrap_inc(input idx_t base);
    begin
      if (base == IDX_W'(DEPTH - 1)) begin
        wrap_inc = '0;
      end else begin
        wrap_inc = base + IDX_W'(1);
      end
    end
  endfunction

endpackage

// ----- hw/rtl/double_ended_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue: bounded deque of signed 32-bit values
//
// Input channel (in_*): one item carries a command in in_tuser and a value in
// in_tdata. Commands: push front, push back, pop front, pop back, read all.
// Result channel (out_*): item value in out_tdata, status in out_tuser, and
// out_tlast on the final result of a command. Unused command codes are taken
// and give no result.
// Entries live in a 16 x 32 synchronous RAM with a registered read.
// A push writes the RAM in the cycle it is taken; its result is registered
// and shows the next cycle. A pop reads the RAM into a read data register,
// which then moves into the output register. Read all streams one result
// per cycle through the same registers while the receiver does not stall,
// one RAM read each. A new item is taken once the previous command has
// placed its last result in the output register and that register is free.
// Reset clears the front index, occupancy and control state; the RAM is not
// cleared, since an entry is only ever read after it was written.
// When the receiver stalls, the output register holds its item and the RAM
// read data is held until the output frees up.
// ----------------------------------------------------------------------------
module double_ended_queue
  import deq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  // input channel
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic signed [VAL_W-1:0] in_tdata,   // [31:0] value
  input  logic        [2:0]       in_tuser,   // [2:0] command
  // result channel
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic signed [VAL_W-1:0] out_tdata,  // [31:0] item
  output logic        [1:0]       out_tuser,  // [1:0] status
  output logic                    out_tlast
);

  typedef enum logic {
    S_IDLE,
    S_STREAM
  } state_t;

  state_t                    state_r, state_nxt;
  idx_t                      front_r, front_nxt;
  cnt_t                      occ_r, occ_nxt;
  cnt_t                      iss_r, iss_nxt;
  cnt_t                      rd_cnt_r, rd_cnt_nxt;
  logic                      rd_pend_r, rd_pend_nxt;
  logic                      rd_last_r, rd_last_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [VAL_W-1:0]   out_data_r, out_data_nxt;
  status_t                   out_status_r, out_status_nxt;
  logic                      out_last_r, out_last_nxt;

  logic                      out_free;
  logic                      take;
  cmd_t                      cmd;
  logic                      mem_we;
  idx_t                      mem_wa;
  logic                      mem_re;
  idx_t                      mem_ra;
  logic [VAL_W-1:0]          mem_rd_r;
  logic [VAL_W-1:0]          mem [DEPTH];

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign take      = in_tvalid && in_tready;
  assign cmd       = cmd_t'(in_tuser);

  // Decode commands, issue RAM accesses and load the output register
  always_comb begin
    state_nxt      = state_r;
    front_nxt      = front_r;
    occ_nxt        = occ_r;
    iss_nxt        = iss_r;
    rd_cnt_nxt     = rd_cnt_r;
    rd_pend_nxt    = rd_pend_r;
    rd_last_nxt    = rd_last_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    mem_wa         = front_r;
    mem_re         = 1'b0;
    mem_ra         = front_r;

    unique case (state_r)
      S_IDLE: begin
        if (take) begin
          case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = '0;
              out_last_nxt  = 1'b1;
              if (occ_r == CNT_W'(DEPTH)) begin
                out_status_nxt = ST_FULL;
              end else begin
                out_status_nxt = ST_OK;
                mem_we         = 1'b1;
                occ_nxt        = occ_r + CNT_W'(1);
                if (cmd == CMD_PUSH_FRONT) begin
                  mem_wa    = wrap_dec(front_r);
                  front_nxt = wrap_dec(front_r);
                end else begin
                  mem_wa = wrap_add(front_r, occ_r);
                end
              end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
              if (occ_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_data_nxt   = '0;
                out_status_nxt = ST_EMPTY;
                out_last_nxt   = 1'b1;
              end else begin
                mem_re      = 1'b1;
                occ_nxt     = occ_r - CNT_W'(1);
                rd_pend_nxt = 1'b1;
                rd_last_nxt = 1'b1;
                iss_nxt     = CNT_W'(1);
                rd_cnt_nxt  = CNT_W'(1);
                state_nxt   = S_STREAM;
                if (cmd == CMD_POP_FRONT) begin
                  mem_ra    = front_r;
                  front_nxt = wrap_inc(front_r);
                end else begin
                  mem_ra = wrap_add(front_r, occ_r - CNT_W'(1));
                end
              end
            end
            CMD_READ_ALL: begin
              if (occ_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_data_nxt   = '0;
                out_status_nxt = ST_EMPTY;
                out_last_nxt   = 1'b1;
              end else begin
                mem_re      = 1'b1;
                mem_ra      = front_r;
                rd_pend_nxt = 1'b1;
                rd_last_nxt = (occ_r == CNT_W'(1));
                iss_nxt     = CNT_W'(1);
                rd_cnt_nxt  = occ_r;
                state_nxt   = S_STREAM;
              end
            end
            default: begin
              // unused codes: drop the item
            end
          endcase
        end
      end

      S_STREAM: begin
        // Move read data to the output once it is free
        if (rd_pend_r && out_free) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = mem_rd_r;
          out_status_nxt = ST_OK;
          out_last_nxt   = rd_last_r;
          rd_pend_nxt    = 1'b0;
          if (rd_last_r) begin
            state_nxt = S_IDLE;
          end
        end
        // Issue the next read when the read data slot will be empty
        if ((iss_r < rd_cnt_r) && (!rd_pend_r || out_free)) begin
          mem_re      = 1'b1;
          mem_ra      = wrap_add(front_r, iss_r);
          iss_nxt     = iss_r + CNT_W'(1);
          rd_pend_nxt = 1'b1;
          rd_last_nxt = ((iss_r + CNT_W'(1)) == rd_cnt_r);
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      occ_r       <= '0;
      iss_r       <= '0;
      rd_cnt_r    <= '0;
      rd_pend_r   <= 1'b0;
      rd_last_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      occ_r       <= occ_nxt;
      iss_r       <= iss_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      rd_pend_r   <= rd_pend_nxt;
      rd_last_r   <= rd_last_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  // Entry RAM: one write and one registered read per cycle. A write and a
  // read of the same entry never fall in the same cycle, since a command
  // only starts once the previous one has finished with the RAM.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= in_tdata;
    end
    if (mem_re) begin
      mem_rd_r <= mem[mem_ra];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

endmodule

// ----- dv/tb_double_ended_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_double_ended_queue: self-checking bench for the double-ended queue
// Walks a directed table of commands (empty, full, extremes, unused codes),
// then random phases that lean towards filling, draining or mixed traffic.
// A local deque model predicts results (typed rows take theirs from the table);
// the output monitor compares each accepted result with the oldest prediction.
// Both channels idle at random, except in the closing stretch.
// ----------------------------------------------------------------------------
module tb_double_ended_queue;
  import deq_pkg::*;

  localparam int          HALF_PERIOD  = 4;
  localparam int          RESET_CYCLES = 6;
  localparam int          RANDOM_ITEMS = 300;
  localparam int          CALM_ITEMS   = 60;
  localparam int          TAIL_CYCLES  = 8;
  localparam int          RUN_LIMIT_NS = 5_000_000;
  localparam logic [2:0]  CMD_RSVD_5   = 3'd5;
  localparam logic [2:0]  CMD_RSVD_6   = 3'd6;
  localparam logic [2:0]  CMD_RSVD_7   = 3'd7;

  typedef struct {
    logic signed [VAL_W-1:0] item;
    status_t                 status;
    logic                    last;
  } deq_result_t;

  typedef struct {
    logic [2:0]              cmd;
    logic signed [VAL_W-1:0] value;
    int                      reps;
    bit                      typed;
    status_t                 status;
  } stim_row_t;

  typedef enum int {FILL_PHASE, DRAIN_PHASE, MIXED_PHASE} phase_mode_t;

  logic                    clk        = 1'b0;
  logic                    rst_n      = 1'b0;
  logic                    in_tvalid  = 1'b0;
  logic                    in_tready;
  logic signed [VAL_W-1:0] in_tdata   = '0;
  logic        [2:0]       in_tuser   = '0;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic signed [VAL_W-1:0] out_tdata;
  logic        [1:0]       out_tuser;
  logic                    out_tlast;

  // Model state of the deque
  logic signed [VAL_W-1:0] model_store [DEPTH];
  idx_t                    model_front;
  cnt_t                    model_count;

  deq_result_t pending_results [$];
  int          failures    = 0;
  bit          calm        = 1'b0;
  int          ready_stall = 0;

  // Directed table: typed rows carry a status that is plain from the state
  stim_row_t directed_rows [23] = '{
    '{CMD_POP_FRONT,  32'sh0000_0000, 1, 1'b1, ST_EMPTY},
    '{CMD_POP_BACK,   32'sh0000_0000, 1, 1'b1, ST_EMPTY},
    '{CMD_READ_ALL,   32'sh0000_0000, 1, 1'b1, ST_EMPTY},
    '{CMD_RSVD_5,     32'sh0000_1234, 1, 1'b0, ST_OK},
    '{CMD_PUSH_BACK,  32'sh7FFF_FFFF, 1, 1'b1, ST_OK},
    '{CMD_PUSH_FRONT, 32'sh8000_0000, 1, 1'b1, ST_OK},
    '{CMD_PUSH_BACK,  32'shFFFF_FFFF, 1, 1'b1, ST_OK},
    '{CMD_PUSH_FRONT, 32'sh0000_0000, 1, 1'b1, ST_OK},
    '{CMD_READ_ALL,   32'sh0000_0000, 1, 1'b0, ST_OK},
    '{CMD_POP_FRONT,  32'sh0000_0000, 1, 1'b0, ST_OK},
    '{CMD_POP_BACK,   32'sh0000_0000, 1, 1'b0, ST_OK},
    '{CMD_RSVD_6,     32'shFFFF_FFFF, 1, 1'b0, ST_OK},
    '{CMD_POP_FRONT,  32'sh0000_0000, 1, 1'b0, ST_OK},
    '{CMD_POP_BACK,   32'sh0000_0000, 1, 1'b0, ST_OK},
    // empty again, with the front index back at zero after wrapping
    '{CMD_POP_BACK,   32'sh0000_0000, 1, 1'b1, ST_EMPTY},
    '{CMD_PUSH_FRONT, 32'sh0000_0100, 9, 1'b1, ST_OK},
    '{CMD_PUSH_BACK,  32'sh0000_0200, 7, 1'b1, ST_OK},
    '{CMD_PUSH_BACK,  32'sh5555_5555, 1, 1'b1, ST_FULL},
    '{CMD_PUSH_FRONT, 32'shAAAA_AAAA, 1, 1'b1, ST_FULL},
    '{CMD_RSVD_7,     32'sh0000_0000, 1, 1'b0, ST_OK},
    '{CMD_READ_ALL,   32'sh0000_0000, 1, 1'b0, ST_OK},
    '{CMD_POP_BACK,   32'sh0000_0000, 1, 1'b0, ST_OK},
    '{CMD_POP_FRONT,  32'sh0000_0000, 1, 1'b0, ST_OK}
  };

  double_ended_queue dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #HALF_PERIOD clk = ~clk;

  // Apply one command to the model deque; return the number of results
  function automatic int deque_predict(input logic [2:0] cmd,
                                       input logic signed [VAL_W-1:0] value,
                                       output deq_result_t res [DEPTH]);
    int n;
    int k;
    int pos;
    begin
      n = 1;
      res[0] = '{item: '0, status: ST_OK, last: 1'b1};
      case (cmd)
        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
          if (model_count == DEPTH) begin
            res[0].status = ST_FULL;
          end else if (cmd == CMD_PUSH_FRONT) begin
            model_front = idx_t'((int'(model_front) + DEPTH - 1) % DEPTH);
            model_store[model_front] = value;
            model_count++;
          end else begin
            pos = (int'(model_front) + int'(model_count)) % DEPTH;
            model_store[pos] = value;
            model_count++;
          end
        end
        CMD_POP_FRONT, CMD_POP_BACK: begin
          if (model_count == 0) begin
            res[0].status = ST_EMPTY;
          end else if (cmd == CMD_POP_FRONT) begin
            res[0].item = model_store[model_front];
            model_front = idx_t'((int'(model_front) + 1) % DEPTH);
            model_count--;
          end else begin
            pos = (int'(model_front) + int'(model_count) - 1) % DEPTH;
            res[0].item = model_store[pos];
            model_count--;
          end
        end
        CMD_READ_ALL: begin
          if (model_count == 0) begin
            res[0].status = ST_EMPTY;
          end else begin
            n = int'(model_count);
            for (k = 0; k < n; k++) begin
              pos = (int'(model_front) + k) % DEPTH;
              res[k] = '{item: model_store[pos], status: ST_OK, last: (k == n - 1)};
            end
          end
        end
        default: begin
          n = 0;
        end
      endcase
      return n;
    end
  endfunction

  // Offer one item after an optional gap, then queue what it should cause
  task automatic send_command(input logic [2:0] cmd,
                              input logic signed [VAL_W-1:0] value,
                              input bit typed, input status_t status);
    deq_result_t res [DEPTH];
    int          n;
    int          k;
    begin
      if (!calm && $urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 13)) begin
          @(negedge clk) in_tvalid <= 1'b0;
        end
      end
      @(negedge clk);
      in_tvalid <= 1'b1;
      in_tuser  <= cmd;
      in_tdata  <= value;
      do @(posedge clk); while (!in_tready);
      n = deque_predict(cmd, value, res);
      if (typed) begin
        pending_results.push_back('{item: '0, status: status, last: 1'b1});
      end else begin
        for (k = 0; k < n; k++) begin
          pending_results.push_back(res[k]);
        end
      end
    end
  endtask

  // Hold the sender off until every predicted result has arrived
  task automatic wait_for_results();
    begin
      do begin
        @(negedge clk) in_tvalid <= 1'b0;
      end while (pending_results.size() != 0);
    end
  endtask

  // Receiver back-pressure in random bursts
  always @(negedge clk) begin
    if (ready_stall > 0) begin
      ready_stall--;
      out_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      ready_stall = $urandom_range(1, 13) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    deq_result_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: item %0d status %0d last %0d",
               out_tdata, out_tuser, out_tlast);
        failures++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_tdata !== exp_res.item) begin
          $error("item: expected %0d, got %0d", exp_res.item, out_tdata);
          failures++;
        end
        if (out_tuser !== exp_res.status) begin
          $error("status: expected %0d, got %0d", exp_res.status, out_tuser);
          failures++;
        end
        if (out_tlast !== exp_res.last) begin
          $error("last: expected %0d, got %0d", exp_res.last, out_tlast);
          failures++;
        end
      end
    end
  end

  // Stop a hung run
  initial begin
    #RUN_LIMIT_NS;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int                      row;
    int                      r;
    int                      j;
    int                      counted;
    int                      phase_len;
    int                      roll;
    int                      push_share;
    int                      pop_share;
    phase_mode_t             mode;
    logic [2:0]              cmd;
    logic signed [VAL_W-1:0] value;

    model_front = '0;
    model_count = '0;
    for (j = 0; j < DEPTH; j++) begin
      model_store[j] = '0;
    end

    // Hold reset, then release on a falling edge
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed table
    for (row = 0; row < $size(directed_rows); row++) begin
      for (r = 0; r < directed_rows[row].reps; r++) begin
        send_command(directed_rows[row].cmd, directed_rows[row].value + r,
                     directed_rows[row].typed, directed_rows[row].status);
      end
    end
    wait_for_results();

    // Random phases, each biased towards filling, draining or mixed traffic
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      mode      = phase_mode_t'($urandom_range(0, 2));
      phase_len = $urandom_range(15, 45);
      push_share = (mode == FILL_PHASE) ? 70 : (mode == DRAIN_PHASE) ? 15 : 40;
      pop_share  = (mode == FILL_PHASE) ? 15 : (mode == DRAIN_PHASE) ? 70 : 40;
      for (j = 0; j < phase_len && counted < RANDOM_ITEMS; j++) begin
        calm = (counted >= RANDOM_ITEMS - CALM_ITEMS);
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
          cmd = 3'($urandom_range(int'(CMD_RSVD_5), int'(CMD_RSVD_7)));
        end else if (roll < 4 + push_share) begin
          cmd = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
        end else if (roll < 4 + push_share + pop_share) begin
          cmd = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
        end else begin
          cmd = CMD_READ_ALL;
        end
        if ($urandom_range(0, 7) == 0) begin
          case ($urandom_range(0, 3))
            0:       value = 32'sh7FFF_FFFF;
            1:       value = 32'sh8000_0000;
            2:       value = '0;
            default: value = 32'shFFFF_FFFF;
          endcase
        end else begin
          value = $urandom;
        end
        send_command(cmd, value, 1'b0, ST_OK);
        if (cmd <= CMD_READ_ALL) begin
          counted++;
        end
      end
      // Let the block run dry between phases
      wait_for_results();
    end

    // Allow any stray result to show before the verdict
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
